// File: src/gcgf_pkg.sv
// Package: shared constants, types and action codes for the gene field codec.
package gcgf_pkg;
  localparam int ChromBitsDefault = 256;
  localparam int WordBits = 32;

  localparam logic [1:0] ActLoad   = 2'd0;
  localparam logic [1:0] ActRead   = 2'd1;
  localparam logic [1:0] ActEncode = 2'd2;
  localparam logic [1:0] ActDecode = 2'd3;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  word_index;
    logic [31:0] word_data;
    logic [31:0] value_in;
    logic [7:0]  start_bit;
    logic [5:0]  bit_length;
    logic [31:0] low_limit;
    logic [31:0] high_limit;
    logic        use_range;
    logic        signed_values;
  } req_t;

  typedef struct packed {
    logic [31:0] value_out;
    logic [8:0]  next_position;
    logic        status;
  } rsp_t;

  // Divider control between sequencer and remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] remainder;
  } div_rsp_t;

  function automatic logic lt_ord(logic [31:0] a, logic [31:0] b, logic sgn);
    logic [31:0] fa;
    logic [31:0] fb;
    fa = sgn ? (a ^ 32'h8000_0000) : a;
    fb = sgn ? (b ^ 32'h8000_0000) : b;
    return fa < fb;
  endfunction
endpackage

// File: src/gcgf_if.sv
// Interfaces: request and response valid/ready channels.
interface gcgf_req_if;
  logic valid;
  logic ready;
  gcgf_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gcgf_rsp_if;
  logic valid;
  logic ready;
  gcgf_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/gcgf_rem.sv
// Remainder unit: restoring division, one quotient bit per cycle.
module gcgf_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  gcgf_pkg::div_req_t req,
  output gcgf_pkg::div_rsp_t rsp
);
  import gcgf_pkg::*;

  logic [31:0] num_r, num_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], num_r[31]};
    if (req.start) begin
      num_nxt  = req.dividend;
      den_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'(WordBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      if (trial >= {1'b0, den_r}) rem_nxt = trial - {1'b0, den_r};
      else rem_nxt = trial;
      num_nxt = {num_r[30:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r[31:0];

  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 6'd0) else $error("divider busy with zero count");
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r[31:0] < den_r) else $error("remainder not below divisor");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");
endmodule

// File: src/gray_coded_gene_field_codec_core.sv
// Top level: gene field codec with bit-serial field access and serial remainder.
//
//  channel | dir | handshake        | payload
//  in_     | in  | valid/ready      | req_t (action, index, data, field, range)
//  out_    | out | valid/ready      | rsp_t (value_out, next_position, status)
//
// From acceptance to out valid: load/read go straight to the output state;
// encode writes the field serially; decode reads it, runs the Gray prefix
// pass, then the remainder unit for a ranged decode whose span is not 2^32.
// Reset (rst_n low, synchronous) clears the store, the state and out valid.
// A held response stalls only the next request: the block takes a new one
// as soon as the output register is free.
module gray_coded_gene_field_codec_core #(
  parameter int CHROMOSOME_BITS = gcgf_pkg::ChromBitsDefault
) (
  input logic clk,
  input logic rst_n,
  gcgf_req_if.sink   in_ch,
  gcgf_rsp_if.source out_ch
);
  import gcgf_pkg::*;

  localparam int Words = (CHROMOSOME_BITS + 31) / 32;
  localparam int WaW = (Words > 1) ? $clog2(Words) : 1;
  localparam int PosW = $clog2(CHROMOSOME_BITS + 33) + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StBits = 3'd1;
  localparam logic [2:0] StGray = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDivW = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  logic [31:0] store_r [Words];

  logic [2:0]  st_r, st_nxt;
  req_t        rq_r, rq_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [5:0]  k_r, k_nxt;
  logic [31:0] sh_r, sh_nxt;     // serial shift register of field bits
  logic [31:0] lo_r, lo_nxt;
  logic [31:0] hi_r, hi_nxt;
  logic        gb_r, gb_nxt;     // running Gray prefix bit
  rsp_t        o_r, o_nxt;
  logic        ov_r, ov_nxt;
  div_req_t    dq;
  div_rsp_t    dr;

  logic [PosW-1:0] pos;
  logic [31:0]     wsel;
  logic            bit_rd;
  logic [31:0]     span;
  logic [31:0]     clv;
  logic [5:0]      ilen;
  logic            wr_en;
  logic [PosW-1:0] wr_pos;
  logic            wr_bit;

  gcgf_rem u_rem (.clk(clk), .rst_n(rst_n), .req(dq), .rsp(dr));

  assign in_ch.ready  = (st_r == StIdle) && !ov_r;
  assign out_ch.valid = ov_r;
  assign out_ch.data  = o_r;

  // current bit position: start + k for decode, start + len - 1 - k for encode
  always_comb begin
    if (rq_r.action == ActEncode)
      pos = PosW'(rq_r.start_bit) + PosW'(len_r) - PosW'(1) - PosW'(k_r);
    else
      pos = PosW'(rq_r.start_bit) + PosW'(k_r);
    wsel   = store_r[WaW'(pos >> 5)];
    bit_rd = wsel[pos[4:0]];
  end

  assign span = hi_r - lo_r + 32'd1;

  always_comb begin
    st_nxt = st_r;
    rq_nxt = rq_r;
    len_nxt = len_r;
    k_nxt = k_r;
    sh_nxt = sh_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    gb_nxt = gb_r;
    o_nxt = o_r;
    ov_nxt = ov_r;
    dq = '0;
    wr_en = 1'b0;
    wr_pos = pos;
    wr_bit = sh_r[0];
    clv = '0;
    ilen = (in_ch.data.bit_length > 6'd32) ? 6'd32 : in_ch.data.bit_length;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      StIdle: begin
        if (in_ch.valid && in_ch.ready) begin
          rq_nxt = in_ch.data;
          len_nxt = ilen;
          k_nxt = '0;
          gb_nxt = 1'b0;
          if (lt_ord(in_ch.data.high_limit, in_ch.data.low_limit,
                     in_ch.data.signed_values)) begin
            lo_nxt = in_ch.data.high_limit;
            hi_nxt = in_ch.data.low_limit;
          end else begin
            lo_nxt = in_ch.data.low_limit;
            hi_nxt = in_ch.data.high_limit;
          end
          o_nxt = '0;
          if (in_ch.data.action == ActLoad || in_ch.data.action == ActRead) begin
            st_nxt = StOut;
          end else if (PosW'(in_ch.data.start_bit) + PosW'(ilen) >
                       PosW'(CHROMOSOME_BITS)) begin
            o_nxt.status = 1'b1;
            st_nxt = StOut;
          end else begin
            o_nxt.next_position = {1'b0, in_ch.data.start_bit} + {3'b0, ilen};
            if (in_ch.data.action == ActEncode) begin
              clv = in_ch.data.value_in;
              if (in_ch.data.use_range) begin
                if (lt_ord(clv, lo_nxt, in_ch.data.signed_values)) clv = lo_nxt;
                if (lt_ord(hi_nxt, clv, in_ch.data.signed_values)) clv = hi_nxt;
                clv = clv - lo_nxt;
              end
              sh_nxt = clv ^ (clv >> 1);
            end else begin
              sh_nxt = '0;
            end
            // an empty field writes nothing on encode
            if (ilen != 6'd0) st_nxt = StBits;
            else if (in_ch.data.action == ActEncode) st_nxt = StOut;
            else st_nxt = StGray;
          end
        end
      end
      StBits: begin
        // move one field bit per cycle
        if (rq_r.action == ActEncode) begin
          wr_en = 1'b1;
          sh_nxt = sh_r >> 1;
        end else begin
          sh_nxt = {sh_r[30:0], bit_rd};
        end
        k_nxt = k_r + 6'd1;
        if (k_r + 6'd1 == len_r) begin
          k_nxt = '0;
          st_nxt = (rq_r.action == ActEncode) ? StOut : StGray;
        end
      end
      StGray: begin
        // Gray decode MSB first: rotate through, xoring the prefix
        if (len_r == 6'd0) begin
          sh_nxt = '0;
          st_nxt = StDiv;
        end else begin
          gb_nxt = gb_r ^ sh_r[31];
          sh_nxt = {sh_r[30:0], gb_r ^ sh_r[31]};
          k_nxt = k_r + 6'd1;
          if (k_r == 6'd31) st_nxt = StDiv;
        end
      end
      StDiv: begin
        if (rq_r.use_range) begin
          if (span == 32'd0) begin
            o_nxt.value_out = sh_r + lo_r;
            st_nxt = StOut;
          end else begin
            dq.start = 1'b1;
            dq.dividend = sh_r;
            dq.divisor = span;
            st_nxt = StDivW;
          end
        end else begin
          o_nxt.value_out = sh_r;
          if (rq_r.signed_values && len_r != 6'd0 && len_r != 6'd32 &&
              sh_r[len_r[4:0] - 5'd1])
            o_nxt.value_out = sh_r | ~((32'd1 << len_r[4:0]) - 32'd1);
          st_nxt = StOut;
        end
      end
      StDivW: begin
        if (dr.done) begin
          o_nxt.value_out = dr.remainder + lo_r;
          st_nxt = StOut;
        end
      end
      StOut: begin
        if (rq_r.action == ActRead && 32'(rq_r.word_index) < 32'(Words))
          o_nxt.value_out = store_r[WaW'(rq_r.word_index)];
        ov_nxt = 1'b1;
        st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
      ov_r <= 1'b0;
      for (int i = 0; i < Words; i++) store_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (st_r == StOut && rq_r.action == ActLoad &&
          32'(rq_r.word_index) < 32'(Words))
        store_r[WaW'(rq_r.word_index)] <= rq_r.word_data;
      if (wr_en)
        store_r[WaW'(wr_pos >> 5)][wr_pos[4:0]] <= wr_bit;
    end
    rq_r <= rq_nxt;
    len_r <= len_nxt;
    k_r <= k_nxt;
    sh_r <= sh_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    gb_r <= gb_nxt;
    o_r <= o_nxt;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != StIdle) |-> !in_ch.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(o_r)) else $error("response dropped");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_r.status) |-> o_r.value_out == 32'd0 && o_r.next_position == 9'd0)
    else $error("error response carries data");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    dr.done |-> st_r == StDivW) else $error("divider done out of sequence");
endmodule

// File: dv/gcgf_checker.sv
// Checker: watches both channels, predicts each response and compares it.
`timescale 1ns / 100ps
module gcgf_checker #(
  parameter int CHROMOSOME_BITS = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  logic req_ready,
  input  gcgf_pkg::req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  gcgf_pkg::rsp_t rsp,
  output int   errors,
  output int   pending
);
  import gcgf_pkg::*;

  localparam int Words = (CHROMOSOME_BITS + 31) / 32;

  logic [31:0] genome[Words];
  rsp_t        expected_rsps[$];

  function automatic logic below(logic [31:0] a, logic [31:0] b, logic sgn);
    if (sgn) begin
      return $signed(a) < $signed(b);
    end
    return a < b;
  endfunction

  function automatic logic [31:0] gray_to_bin(logic [31:0] g);
    logic [31:0] b;
    b[31] = g[31];
    for (int i = 30; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

  // Apply one request to the shadow genome and return its response.
  function automatic rsp_t codec_result(req_t r);
    rsp_t        res;
    logic [31:0] lo, hi, v, span;
    int          len, pos;
    res = '0;
    len = (r.bit_length > 32) ? 32 : int'(r.bit_length);
    if (below(r.high_limit, r.low_limit, r.signed_values)) begin
      lo = r.high_limit;
      hi = r.low_limit;
    end else begin
      lo = r.low_limit;
      hi = r.high_limit;
    end
    case (r.action)
      ActLoad: begin
        if (r.word_index < Words) genome[r.word_index] = r.word_data;
      end
      ActRead: begin
        if (r.word_index < Words) res.value_out = genome[r.word_index];
      end
      default: begin
        if (int'(r.start_bit) + len > CHROMOSOME_BITS) begin
          res.status = 1'b1;
        end else if (r.action == ActEncode) begin
          v = r.value_in;
          if (r.use_range) begin
            if (below(v, lo, r.signed_values)) v = lo;
            if (below(hi, v, r.signed_values)) v = hi;
            v = v - lo;
          end
          v = v ^ (v >> 1);
          for (int k = 0; k < len; k++) begin
            pos = int'(r.start_bit) + len - 1 - k;
            genome[(pos >> 5) % Words][pos & 31] = v[k];
          end
          res.next_position = 9'(int'(r.start_bit) + len);
        end else begin
          v = '0;
          for (int k = 0; k < len; k++) begin
            pos = int'(r.start_bit) + k;
            v = {v[30:0], genome[(pos >> 5) % Words][pos & 31]};
          end
          v = gray_to_bin(v);
          if (r.use_range) begin
            span = hi - lo + 32'd1;
            if (span != 0) v = v % span;
            v = v + lo;
          end else if (r.signed_values && len > 0 && len < 32) begin
            if (v[len-1]) v = v | ~((32'd1 << len) - 32'd1);
          end
          res.value_out = v;
          res.next_position = 9'(int'(r.start_bit) + len);
        end
      end
    endcase
    return res;
  endfunction

  assign pending = expected_rsps.size();

  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      for (int w = 0; w < Words; w++) genome[w] = '0;
      expected_rsps.delete();
      errors <= 0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(codec_result(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          if (errors < 10) $display("unexpected response %h", rsp);
          errors <= errors + 1;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.value_out !== want.value_out || rsp.next_position !== want.next_position
              || rsp.status !== want.status) begin
            if (errors < 10) begin
              $display("mismatch: value %h/%h next %0d/%0d status %0d/%0d (exp/act)",
                       want.value_out, rsp.value_out, want.next_position,
                       rsp.next_position, want.status, rsp.status);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// File: dv/tb_top.sv
// Testbench top: drives requests and response stalls, gives the verdict.
`timescale 1ns / 100ps
module tb_top;
  import gcgf_pkg::*;

  localparam int  NumRandom = 1500;
  localparam longint CycleLimit = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors, pending;
  longint cycles = 0;
  logic sink_stall = 1'b0;
  req_t dir_reqs[$];

  gcgf_req_if in_ch ();
  gcgf_rsp_if out_ch ();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gray_coded_gene_field_codec_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  gcgf_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(in_ch.valid),
    .req_ready(in_ch.ready),
    .req      (in_ch.data),
    .rsp_valid(out_ch.valid),
    .rsp_ready(out_ch.ready),
    .rsp      (out_ch.data),
    .errors   (errors),
    .pending  (pending)
  );

  // Receiver stalls: runs of ready and of stall, sometimes none at all.
  int stall_run = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_run = $urandom_range(1, 40);
        sink_stall = ($urandom_range(0, 3) == 0) ? ~sink_stall : 1'b0;
      end
      stall_run--;
      out_ch.ready <= sink_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic req_t rand_req();
    req_t r;
    logic [31:0] a, b;
    r = '0;
    r.action        = 2'($urandom_range(0, 3));
    r.word_index    = 3'($urandom);
    r.word_data     = $urandom;
    r.value_in      = $urandom;
    r.start_bit     = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 224));
    r.bit_length    = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
    a = $urandom;
    b = ($urandom_range(0, 1) != 0) ? a + $urandom_range(0, 1000) : $urandom;
    r.low_limit     = a;
    r.high_limit    = b;
    r.use_range     = 1'($urandom);
    r.signed_values = 1'($urandom);
    // Bias toward values near the low limit so clamping is not always active.
    if ($urandom_range(0, 1) != 0) r.value_in = a + $urandom_range(0, 2000) - 500;
    return r;
  endfunction

  function automatic req_t mk(logic [1:0] act, logic [7:0] st, logic [5:0] len,
                              logic [31:0] val, logic rng, logic sgn,
                              logic [31:0] lo, logic [31:0] hi);
    req_t r;
    r = '0;
    r.action = act;
    r.start_bit = st;
    r.bit_length = len;
    r.value_in = val;
    r.use_range = rng;
    r.signed_values = sgn;
    r.low_limit = lo;
    r.high_limit = hi;
    return r;
  endfunction

  task automatic send(req_t r);
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    req_t r;
    int   burst;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: word load and read, extremes, empty, overlong and out-of-range fields.
    r = '0; r.action = ActLoad; r.word_index = 3'd7; r.word_data = 32'hFFFF_FFFF;
    dir_reqs.push_back(r);
    r.word_index = 3'd0; r.word_data = 32'hA5A5_0F0F; dir_reqs.push_back(r);
    r.action = ActRead; dir_reqs.push_back(r);
    r.word_index = 3'd7; dir_reqs.push_back(r);
    dir_reqs.push_back(mk(ActEncode, 8'd0, 6'd32, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd0, 6'd32, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd0, 6'd32, 32'd0, 1'b1, 1'b0, 32'd0, 32'hFFFF_FFFF));
    dir_reqs.push_back(mk(ActEncode, 8'd224, 6'd32, 32'h8000_0000, 1'b0, 1'b1, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActEncode, 8'd225, 6'd32, 32'd5, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd255, 6'd2, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActEncode, 8'd10, 6'd0, 32'd7, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActEncode, 8'd10, 6'd0, 32'd7, 1'b1, 1'b0, 32'd9, 32'd20));
    dir_reqs.push_back(mk(ActDecode, 8'd10, 6'd0, 32'd0, 1'b1, 1'b1, 32'hFFFF_FFF0, 32'd5));
    dir_reqs.push_back(mk(ActEncode, 8'd40, 6'd63, 32'h1234_5678, 1'b0, 1'b0, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd40, 6'd40, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActEncode, 8'd100, 6'd5, 32'hFFFF_FFF0, 1'b1, 1'b1, 32'd3,
                          32'hFFFF_FFF8));
    dir_reqs.push_back(mk(ActDecode, 8'd100, 6'd5, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd100, 6'd5, 32'd0, 1'b1, 1'b1, 32'd3, 32'hFFFF_FFF8));
    dir_reqs.push_back(mk(ActEncode, 8'd120, 6'd8, 32'd999, 1'b1, 1'b0, 32'd200, 32'd10));
    dir_reqs.push_back(mk(ActDecode, 8'd120, 6'd8, 32'd0, 1'b1, 1'b0, 32'd200, 32'd10));
    dir_reqs.push_back(mk(ActDecode, 8'd120, 6'd1, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0));
    dir_reqs.push_back(mk(ActDecode, 8'd0, 6'd31, 32'd0, 1'b1, 1'b1, 32'h8000_0000,
                          32'h7FFF_FFFF));
    r = '0; r.action = ActRead; r.word_index = 3'd3; dir_reqs.push_back(r);
    foreach (dir_reqs[i]) send(dir_reqs[i]);
    in_ch.valid <= 1'b0;

    // Hold off until every response has drained.
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 30);
      for (int b = 0; b < burst && n < NumRandom; b++, n++) send(rand_req());
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
